@@ design/deq_pkg.sv @@
// Shared types and defaults for the double-ended queue.
`default_nettype none

package deq_pkg;

  localparam int unsigned DepthDef = 16;
  localparam int unsigned WidthDef = 32;
  localparam int unsigned PortW    = 32;

  typedef enum logic [1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_PUSH_BACK  = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_BACK   = 2'd3
  } mode_e;

  // Operation broadcast to every cell; at most one bit is set, and only for
  // an operation that succeeds.
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
  } cell_ctrl_t;

  // Occupancy seen at the ends of the chain.
  typedef struct packed {
    logic full;
    logic empty;
  } occ_t;

endpackage

`default_nettype wire

@@ design/deq_cell.sv @@
// One storage cell of the queue chain: a word, its valid flag and neighbor moves.
`default_nettype none

module deq_cell
  import deq_pkg::*;
#(
  parameter int unsigned WIDTH = WidthDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cell_ctrl_t       ctrl_i,
  input  wire logic [WIDTH-1:0] word_i,
  input  wire logic [WIDTH-1:0] left_data_i,
  input  wire logic             left_valid_i,
  input  wire logic [WIDTH-1:0] right_data_i,
  input  wire logic             right_valid_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  valid_o,
  output logic                  last_o
);

  logic [WIDTH-1:0] data_q, data_d;
  logic             valid_q, valid_d;

  // This cell holds the back entry when it is filled and its right
  // neighbor is not.
  assign last_o = valid_q && !right_valid_i;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    if (ctrl_i.push_front) begin
      data_d  = left_data_i;
      valid_d = left_valid_i;
    end else if (ctrl_i.push_back) begin
      // The first empty cell takes the word.
      if (!valid_q && left_valid_i) begin
        data_d  = word_i;
        valid_d = 1'b1;
      end
    end else if (ctrl_i.pop_front) begin
      data_d  = right_data_i;
      valid_d = right_valid_i;
    end else if (ctrl_i.pop_back) begin
      if (last_o) begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

@@ design/deq_chain.sv @@
// Row of queue cells, packed from the front, with end flags and end reads.
`default_nettype none

module deq_chain
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDef,
  parameter int unsigned WIDTH = WidthDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cell_ctrl_t       ctrl_i,
  input  wire logic [WIDTH-1:0] word_i,
  output occ_t                  occ_o,
  output logic      [WIDTH-1:0] front_data_o,
  output logic      [WIDTH-1:0] back_data_o
);

  logic [WIDTH-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0] cell_valid;
  logic [DEPTH-1:0] cell_last;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] left_data;
    logic             left_valid;
    logic [WIDTH-1:0] right_data;
    logic             right_valid;

    if (i == 0) begin : g_head
      // The head sees the incoming word as a filled left neighbor.
      assign left_data  = word_i;
      assign left_valid = 1'b1;
    end else begin : g_body
      assign left_data  = cell_data[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_data  = cell_data[i+1];
      assign right_valid = cell_valid[i+1];
    end

    deq_cell #(
      .WIDTH(WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl_i),
      .word_i       (word_i),
      .left_data_i  (left_data),
      .left_valid_i (left_valid),
      .right_data_i (right_data),
      .right_valid_i(right_valid),
      .data_o       (cell_data[i]),
      .valid_o      (cell_valid[i]),
      .last_o       (cell_last[i])
    );
  end

  assign occ_o.full    = cell_valid[DEPTH-1];
  assign occ_o.empty   = !cell_valid[0];
  assign front_data_o  = cell_data[0];

  // At most one cell flags itself as the back entry.
  always_comb begin
    back_data_o = '0;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      back_data_o = back_data_o | ({WIDTH{cell_last[i]}} & cell_data[i]);
    end
  end

endmodule

`default_nettype wire

@@ design/double_ended_queue.sv @@
// Top level of the double-ended queue: decode, result register and handshake.
//
//   channel | direction | handshake              | payload
//   input   | in        | in_valid_i / in_stall_o  | mode_i, data_in_i
//   output  | out       | out_valid_o / out_stall_i | data_out_o, status_o
//
// Each accepted beat is applied to the cell chain; its result
// appears in the output register on the next cycle, one beat per cycle while in_stall_o is low.
// The chain of DEPTH cells shifts all words together for front operations.
// Reset clears every cell's valid flag, so the queue starts empty.
// A new beat is taken while the result register is free or being drained;
// in_stall_o rises only while a result waits and out_stall_i is high.
`default_nettype none

module double_ended_queue
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDef,
  parameter int unsigned WIDTH = WidthDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [1:0]       mode_i,
  input  wire logic [PortW-1:0] data_in_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic      [PortW-1:0] data_out_o,
  output logic                  status_o
);

  logic             accept;
  mode_e            mode;
  cell_ctrl_t       ctrl;
  occ_t             occ;
  logic [WIDTH-1:0] word;
  logic [WIDTH-1:0] front_data;
  logic [WIDTH-1:0] back_data;
  logic [WIDTH-1:0] pop_data;
  logic [PortW-1:0] pop_word;
  logic             fail;

  logic             out_valid_q, out_valid_d;
  logic [PortW-1:0] data_out_q, data_out_d;
  logic             status_q, status_d;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign mode       = mode_e'(mode_i);

  for (genvar b = 0; b < WIDTH; b++) begin : g_word
    if (b < PortW) begin : g_bit
      assign word[b] = data_in_i[b];
    end else begin : g_pad
      assign word[b] = 1'b0;
    end
  end

  always_comb begin
    ctrl     = '0;
    fail     = 1'b0;
    pop_data = '0;
    unique case (mode)
      MODE_PUSH_FRONT: begin
        fail            = occ.full;
        ctrl.push_front = accept && !occ.full;
      end
      MODE_PUSH_BACK: begin
        fail           = occ.full;
        ctrl.push_back = accept && !occ.full;
      end
      MODE_POP_FRONT: begin
        fail           = occ.empty;
        ctrl.pop_front = accept && !occ.empty;
        pop_data       = occ.empty ? '0 : front_data;
      end
      MODE_POP_BACK: begin
        fail          = occ.empty;
        ctrl.pop_back = accept && !occ.empty;
        pop_data      = occ.empty ? '0 : back_data;
      end
      default: begin
        fail = 1'b1;
      end
    endcase
  end

  for (genvar b = 0; b < PortW; b++) begin : g_out
    if (b < WIDTH) begin : g_bit
      assign pop_word[b] = pop_data[b];
    end else begin : g_pad
      assign pop_word[b] = 1'b0;
    end
  end

  deq_chain #(
    .DEPTH(DEPTH),
    .WIDTH(WIDTH)
  ) u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .word_i      (word),
    .occ_o       (occ),
    .front_data_o(front_data),
    .back_data_o (back_data)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    data_out_d  = data_out_q;
    status_d    = status_q;
    if (accept) begin
      out_valid_d = 1'b1;
      data_out_d  = pop_word;
      status_d    = fail;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_out_q <= data_out_d;
    status_q   <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign data_out_o  = data_out_q;
  assign status_o    = status_q;

`ifndef SYNTHESIS
  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(occ.full && occ.empty))
    else $error("queue flags report full and empty at once");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted beat produced no result");

  a_empty_pop_fails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && occ.empty && (mode == MODE_POP_FRONT || mode == MODE_POP_BACK))
      |=> (status_o && data_out_o == '0))
    else $error("pop on empty queue did not fail");

  a_push_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (mode == MODE_PUSH_FRONT || mode == MODE_PUSH_BACK))
      |=> (data_out_o == '0 && status_o == $past(occ.full)))
    else $error("push result carries wrong data or status");

  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.push_front || ctrl.push_back) |=> !occ.empty)
    else $error("queue empty after a successful push");
`endif

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for the double-ended queue with a ring-buffer predictor.
`timescale 1ns / 100ps

module tb
  import deq_pkg::*;
();

  localparam int unsigned Depth = DepthDef;
  localparam logic [PortW-1:0] DataMask = {PortW{1'b1}} >> (PortW - WidthDef);
  localparam int RandomOps = 1600;

  typedef struct packed {
    logic [PortW-1:0] data;
    logic             status;
  } deq_result_t;

  typedef struct {
    mode_e            op;
    logic [PortW-1:0] word;
    int               reps;
    bit               known;
    deq_result_t      outcome;
  } op_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [1:0]       mode_i = MODE_PUSH_BACK;
  logic [PortW-1:0] data_in_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [PortW-1:0] data_out_o;
  logic             status_o;

  double_ended_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .data_in_i   (data_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_out_o  (data_out_o),
    .status_o    (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state of the ring.
  logic [PortW-1:0] ring_words [Depth];
  int unsigned      head_idx = 0;
  int unsigned      tail_idx = 0;
  int unsigned      fill_level = 0;

  deq_result_t pending_results [$];
  int          fail_count = 0;
  bit          send_idle_on = 1'b1;
  bit          recv_stall_on = 1'b1;

  function automatic deq_result_t apply_op(mode_e op, logic [PortW-1:0] word);
    deq_result_t r;
    r = '0;
    case (op)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (fill_level >= Depth) begin
          r.status = 1'b1;
        end else begin
          if (op == MODE_PUSH_FRONT) begin
            head_idx = (head_idx == 0) ? Depth - 1 : head_idx - 1;
            ring_words[head_idx] = word & DataMask;
          end else begin
            ring_words[tail_idx] = word & DataMask;
            tail_idx = (tail_idx + 1 >= Depth) ? 0 : tail_idx + 1;
          end
          fill_level++;
        end
      end
      default: begin
        if (fill_level == 0) begin
          r.status = 1'b1;
        end else begin
          if (op == MODE_POP_FRONT) begin
            r.data = ring_words[head_idx];
            head_idx = (head_idx + 1 >= Depth) ? 0 : head_idx + 1;
          end else begin
            tail_idx = (tail_idx == 0) ? Depth - 1 : tail_idx - 1;
            r.data = ring_words[tail_idx];
          end
          fill_level--;
        end
      end
    endcase
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_op(mode_e op, logic [PortW-1:0] word, bit known,
                         deq_result_t outcome);
    int gap;
    deq_result_t predicted;
    gap = send_idle_on ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= op;
    data_in_i  <= word;
    do @(posedge clk_i); while (in_stall_o);
    predicted = apply_op(op, word);
    pending_results.push_back(known ? outcome : predicted);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Result side: a random hold-off before each beat, then stall stays low until one is taken.
  initial begin
    int hold;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      hold = recv_stall_on ? $urandom_range(0, 10) : 0;
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    deq_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: data_out %h status %b", data_out_o, status_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (data_out_o !== want.data) begin
          $error("data_out: expected %h, actual %h", want.data, data_out_o);
          fail_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %b, actual %b", want.status, status_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    op_row_t     rows [$];
    op_row_t     row;
    mode_e       op;
    logic [PortW-1:0] word;
    int          push_pct;
    bit          is_push;
    bit          at_front;

    // Empty pops, both extreme words at both ends, then fill to full and overflow.
    rows.push_back(op_row_t'{MODE_POP_FRONT, 32'h0, 1, 1'b1, '{32'h0, 1'b1}});
    rows.push_back(op_row_t'{MODE_POP_BACK, 32'hFFFF_FFFF, 1, 1'b1, '{32'h0, 1'b1}});
    rows.push_back(op_row_t'{MODE_PUSH_BACK, 32'hFFFF_FFFF, 1, 1'b1, '{32'h0, 1'b0}});
    rows.push_back(op_row_t'{MODE_PUSH_FRONT, 32'h0, 1, 1'b1, '{32'h0, 1'b0}});
    rows.push_back(op_row_t'{MODE_POP_FRONT, 32'h1234_5678, 1, 1'b1, '{32'h0, 1'b0}});
    rows.push_back(op_row_t'{MODE_POP_BACK, 32'h0, 1, 1'b1, '{32'hFFFF_FFFF, 1'b0}});
    rows.push_back(op_row_t'{MODE_PUSH_FRONT, 32'hA5A5_A5A0, 9, 1'b0, '{32'h0, 1'b0}});
    rows.push_back(op_row_t'{MODE_PUSH_BACK, 32'h5A5A_5A50, 7, 1'b0, '{32'h0, 1'b0}});
    rows.push_back(op_row_t'{MODE_PUSH_FRONT, 32'h1234_5678, 1, 1'b1, '{32'h0, 1'b1}});
    rows.push_back(op_row_t'{MODE_PUSH_BACK, 32'h8765_4321, 1, 1'b1, '{32'h0, 1'b1}});

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      row = rows[i];
      for (int r = 0; r < row.reps; r++) begin
        send_op(row.op, row.word + r, row.known, row.outcome);
      end
    end
    drain_results();

    // Random phases lean toward pushes or pops so the queue swings between empty and full.
    push_pct = 50;
    for (int n = 0; n < RandomOps; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: push_pct = 85;
          1: push_pct = 15;
          default: push_pct = 50;
        endcase
      end
      if (n % 100 == 0) begin
        send_idle_on  = ($urandom_range(0, 3) != 0);
        recv_stall_on = ($urandom_range(0, 3) != 0);
      end
      if (n % 400 == 200) drain_results();
      is_push  = ($urandom_range(0, 99) < push_pct);
      at_front = 1'($urandom_range(0, 1));
      if (is_push) op = at_front ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
      else op = at_front ? MODE_POP_FRONT : MODE_POP_BACK;
      case ($urandom_range(0, 7))
        0: word = '0;
        1: word = '1;
        default: word = $urandom;
      endcase
      send_op(op, word, 1'b0, '0);
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ double_ended_queue.f @@
design/deq_pkg.sv
design/deq_cell.sv
design/deq_chain.sv
design/double_ended_queue.sv
sim/tb.sv
